@@ src/glob_wildcard_matcher_macros.svh @@
// Assertion macros used by the gwm_engine RTL file.
`ifndef GLOB_WILDCARD_MATCHER_MACROS_SVH
`define GLOB_WILDCARD_MATCHER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GWM_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gwm: implication check failed");
`define GWM_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gwm: next-cycle check failed");
`else
`define GWM_ASSERT_IMPL(name, ante, cons)
`define GWM_ASSERT_NEXT(name, ante, cons)
`endif
`endif

@@ src/gwm_pkg.sv @@
package gwm_pkg;

	localparam int MAX_PATTERN_DEF = 64;
	localparam int MAX_SUBJECT_DEF = 256;

	localparam logic [7:0] CH_STAR     = 8'h2A;
	localparam logic [7:0] CH_QUES     = 8'h3F;
	localparam logic [7:0] CH_UPPER_A  = 8'h41;
	localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	localparam logic OP_PATTERN = 1'b0;
	localparam logic OP_SUBJECT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic done;
		logic matched;
		logic overflow;
	} result_t;

	function automatic logic [7:0] fold(input logic [7:0] c, input logic mode);
		logic [7:0] r;
		r = c;
		if (mode && (c inside {[CH_UPPER_A:CH_UPPER_Z]})) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

@@ src/glob_wildcard_matcher.sv @@
// Pattern and non-terminating subject bytes: one transaction per cycle while idle,
// no result. Subject zero byte: input stalls while the match walks both memories,
// each compare step a memory read state then an evaluate state; a done state then
// posts the result. An overflowed pair goes from idle to done, without a walk.
// Reset clears lengths, overflow flag and output valid, sets case_mode to 1;
// memory contents are not cleared.
module glob_wildcard_matcher #(
	parameter int MAX_PATTERN = gwm_pkg::MAX_PATTERN_DEF,
	parameter int MAX_SUBJECT = gwm_pkg::MAX_SUBJECT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       operation,
	input  logic [7:0] char_value,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       matched,
	output logic       overflow,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       case_mode
);

	localparam int PAW = $clog2(MAX_PATTERN);
	localparam int SAW = $clog2(MAX_SUBJECT);
	localparam int PLW = $clog2(MAX_PATTERN + 1);
	localparam int SLW = $clog2(MAX_SUBJECT + 1);

	logic           case_mode_q;
	logic [PLW-1:0] plen_q;
	logic [SLW-1:0] slen_q;
	logic           ovf_q;
	logic           out_valid_q, matched_q, overflow_q;

	logic           in_acc, is_zero, pat_wen, sub_wen, pat_full, sub_full, start, take, busy;
	logic [PAW-1:0] pat_raddr;
	logic [SAW-1:0] sub_raddr;
	logic [7:0]     pat_rdata, sub_rdata;
	gwm_pkg::result_t result;

	assign cfg_ready = 1'b1;
	assign in_stall  = busy;
	assign in_acc    = in_valid && !in_stall;
	assign is_zero   = (char_value == 8'd0);
	assign pat_full  = (plen_q == PLW'(MAX_PATTERN));
	assign sub_full  = (slen_q == SLW'(MAX_SUBJECT));
	assign pat_wen   = in_acc && operation == gwm_pkg::OP_PATTERN && !is_zero && !pat_full;
	assign sub_wen   = in_acc && operation == gwm_pkg::OP_SUBJECT && !is_zero && !sub_full;
	assign start     = in_acc && operation == gwm_pkg::OP_SUBJECT && is_zero;
	assign take      = !out_valid_q || !out_stall;

	gwm_mem #(.DEPTH(MAX_PATTERN)) u_pat_mem (
		.clk   (clk),
		.wen   (pat_wen),
		.waddr (plen_q[PAW-1:0]),
		.wdata (char_value),
		.raddr (pat_raddr),
		.rdata (pat_rdata)
	);

	gwm_mem #(.DEPTH(MAX_SUBJECT)) u_sub_mem (
		.clk   (clk),
		.wen   (sub_wen),
		.waddr (slen_q[SAW-1:0]),
		.wdata (char_value),
		.raddr (sub_raddr),
		.rdata (sub_rdata)
	);

	gwm_engine #(
		.MAX_PATTERN (MAX_PATTERN),
		.MAX_SUBJECT (MAX_SUBJECT)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.start_ovf (ovf_q),
		.case_mode (case_mode_q),
		.pat_len   (plen_q),
		.sub_len   (slen_q),
		.pat_rdata (pat_rdata),
		.sub_rdata (sub_rdata),
		.take      (take),
		.pat_raddr (pat_raddr),
		.sub_raddr (sub_raddr),
		.busy      (busy),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			case_mode_q <= 1'b1;
			plen_q      <= '0;
			slen_q      <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case_mode_q <= case_mode;
			end
			if (result.done) begin
				plen_q <= '0;
				slen_q <= '0;
				ovf_q  <= 1'b0;
			end else if (in_acc && !is_zero) begin
				if (operation == gwm_pkg::OP_PATTERN) begin
					if (pat_full) begin
						ovf_q <= 1'b1;
					end else begin
						plen_q <= plen_q + 1'b1;
					end
				end else begin
					if (sub_full) begin
						ovf_q <= 1'b1;
					end else begin
						slen_q <= slen_q + 1'b1;
					end
				end
			end
			if (result.done) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (result.done) begin
			matched_q  <= result.matched;
			overflow_q <= result.overflow;
		end
	end

	assign out_valid = out_valid_q;
	assign matched   = matched_q;
	assign overflow  = overflow_q;

endmodule

@@ src/gwm_mem.sv @@
module gwm_mem #(
	parameter int DEPTH = gwm_pkg::MAX_PATTERN_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wen,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wen) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ src/gwm_engine.sv @@
`include "glob_wildcard_matcher_macros.svh"

module gwm_engine #(
	parameter int MAX_PATTERN = gwm_pkg::MAX_PATTERN_DEF,
	parameter int MAX_SUBJECT = gwm_pkg::MAX_SUBJECT_DEF,
	parameter int PAW = $clog2(MAX_PATTERN),
	parameter int SAW = $clog2(MAX_SUBJECT),
	parameter int PLW = $clog2(MAX_PATTERN + 1),
	parameter int SLW = $clog2(MAX_SUBJECT + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              start_ovf,
	input  logic              case_mode,
	input  logic [PLW-1:0]    pat_len,
	input  logic [SLW-1:0]    sub_len,
	input  logic [7:0]        pat_rdata,
	input  logic [7:0]        sub_rdata,
	input  logic              take,
	output logic [PAW-1:0]    pat_raddr,
	output logic [SAW-1:0]    sub_raddr,
	output logic              busy,
	output gwm_pkg::result_t  result
);

	gwm_pkg::state_t state_q, state_nxt;

	logic [PLW-1:0] p_q, p_nxt, star_p_q, star_p_nxt, p_inc;
	logic [SLW-1:0] s_q, s_nxt, resume_q, resume_nxt, s_inc;
	logic           star_q, star_nxt;
	logic           res_match_q, res_ovf_q;
	logic           fin, fin_match;
	logic           p_end, s_end, pstar, eq;

	assign p_inc = p_q + 1'b1;
	assign s_inc = s_q + 1'b1;
	assign p_end = (p_q == pat_len);
	assign s_end = (s_q == sub_len);
	assign pstar = !p_end && (pat_rdata == gwm_pkg::CH_STAR);
	assign eq    = !p_end && ((gwm_pkg::fold(pat_rdata, case_mode) ==
		gwm_pkg::fold(sub_rdata, case_mode)) || (pat_rdata == gwm_pkg::CH_QUES));

	always_comb begin
		p_nxt      = p_q;
		s_nxt      = s_q;
		star_p_nxt = star_p_q;
		resume_nxt = resume_q;
		star_nxt   = star_q;
		fin        = 1'b0;
		fin_match  = 1'b0;
		if (s_end) begin
			if (p_end) begin
				fin       = 1'b1;
				fin_match = 1'b1;
			end else if (pstar) begin
				p_nxt = p_inc;
			end else begin
				fin = 1'b1;
			end
		end else if (pstar) begin
			p_nxt = p_inc;
			if (p_inc == pat_len) begin
				fin       = 1'b1;
				fin_match = 1'b1;
			end else begin
				star_p_nxt = p_inc;
				resume_nxt = s_inc;
				star_nxt   = 1'b1;
			end
		end else if (eq) begin
			p_nxt = p_inc;
			s_nxt = s_inc;
		end else if (star_q) begin
			p_nxt      = star_p_q;
			s_nxt      = resume_q;
			resume_nxt = resume_q + 1'b1;
		end else begin
			fin = 1'b1;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			gwm_pkg::ST_IDLE: begin
				if (start) begin
					state_nxt = start_ovf ? gwm_pkg::ST_DONE : gwm_pkg::ST_READ;
				end
			end
			gwm_pkg::ST_READ: state_nxt = gwm_pkg::ST_EVAL;
			gwm_pkg::ST_EVAL: state_nxt = fin ? gwm_pkg::ST_DONE : gwm_pkg::ST_READ;
			gwm_pkg::ST_DONE: begin
				if (take) begin
					state_nxt = gwm_pkg::ST_IDLE;
				end
			end
			default: state_nxt = gwm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy            = (state_q != gwm_pkg::ST_IDLE);
		pat_raddr       = p_q[PAW-1:0];
		sub_raddr       = s_q[SAW-1:0];
		result.done     = (state_q == gwm_pkg::ST_DONE) && take;
		result.matched  = res_match_q;
		result.overflow = res_ovf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gwm_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == gwm_pkg::ST_IDLE && start) begin
			p_q         <= '0;
			s_q         <= '0;
			star_p_q    <= '0;
			resume_q    <= '0;
			star_q      <= 1'b0;
			res_match_q <= 1'b0;
			res_ovf_q   <= start_ovf;
		end else if (state_q == gwm_pkg::ST_EVAL) begin
			p_q      <= p_nxt;
			s_q      <= s_nxt;
			star_p_q <= star_p_nxt;
			resume_q <= resume_nxt;
			star_q   <= star_nxt;
			if (fin) begin
				res_match_q <= fin_match;
			end
		end
	end

	`GWM_ASSERT_IMPL(a_start_idle, start, state_q == gwm_pkg::ST_IDLE)
	`GWM_ASSERT_NEXT(a_read_eval, state_q == gwm_pkg::ST_READ, state_q == gwm_pkg::ST_EVAL)
	`GWM_ASSERT_IMPL(a_p_range, state_q == gwm_pkg::ST_EVAL, p_q <= pat_len)
	`GWM_ASSERT_IMPL(a_s_range, state_q == gwm_pkg::ST_EVAL, s_q <= sub_len)
	`GWM_ASSERT_IMPL(a_res_excl, result.done, !(result.matched && result.overflow))

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

	typedef logic [7:0] byte_q_t[$];

	typedef struct packed {
		logic matched;
		logic overflow;
	} verdict_t;

	class match_tracker;
		logic [7:0] pat_bytes[$];
		logic [7:0] sub_bytes[$];
		bit overflowed;
		bit fold_case = 1'b1;
		verdict_t pending_verdicts[$];
		int failures;
		int n_hit;
		int n_miss;
		int n_overflow;

		function logic [7:0] canon(logic [7:0] c);
			if (fold_case && c >= gwm_pkg::CH_UPPER_A && c <= gwm_pkg::CH_UPPER_Z)
				return c + gwm_pkg::CASE_OFFSET;
			return c;
		endfunction

		function logic [7:0] pat_at(int i);
			return (i < pat_bytes.size()) ? pat_bytes[i] : 8'h00;
		endfunction

		function logic [7:0] sub_at(int i);
			return (i < sub_bytes.size()) ? sub_bytes[i] : 8'h00;
		endfunction

		function bit glob_match();
			int p;
			int s;
			int star_p;
			int resume_s;
			logic [7:0] pc;
			p = 0;
			s = 0;
			star_p = 0;
			resume_s = 0;
			while (sub_at(s) != 0 && pat_at(p) != gwm_pkg::CH_STAR) begin
				pc = pat_at(p);
				if (canon(pc) != canon(sub_at(s)) && pc != gwm_pkg::CH_QUES)
					return 1'b0;
				p++;
				s++;
			end
			while (sub_at(s) != 0) begin
				pc = pat_at(p);
				if (pc == gwm_pkg::CH_STAR) begin
					p++;
					if (pat_at(p) == 0)
						return 1'b1;
					star_p = p;
					resume_s = s + 1;
				end else if (canon(pc) == canon(sub_at(s)) || pc == gwm_pkg::CH_QUES) begin
					p++;
					s++;
				end else begin
					p = star_p;
					s = resume_s;
					resume_s++;
				end
			end
			while (pat_at(p) == gwm_pkg::CH_STAR)
				p++;
			return pat_at(p) == 0;
		endfunction

		function void take_byte(logic op, logic [7:0] c);
			verdict_t v;
			if (op == gwm_pkg::OP_PATTERN) begin
				if (c != 0) begin
					if (pat_bytes.size() < gwm_pkg::MAX_PATTERN_DEF)
						pat_bytes.push_back(c);
					else
						overflowed = 1'b1;
				end
			end else if (c != 0) begin
				if (sub_bytes.size() < gwm_pkg::MAX_SUBJECT_DEF)
					sub_bytes.push_back(c);
				else
					overflowed = 1'b1;
			end else begin
				v.overflow = overflowed;
				v.matched = overflowed ? 1'b0 : glob_match();
				pending_verdicts.push_back(v);
				if (v.overflow)
					n_overflow++;
				else if (v.matched)
					n_hit++;
				else
					n_miss++;
				pat_bytes.delete();
				sub_bytes.delete();
				overflowed = 1'b0;
			end
		endfunction

		function void check_verdict(logic m, logic o);
			verdict_t v;
			if (pending_verdicts.size() == 0) begin
				$error("result transaction with none pending: matched %0d overflow %0d", m, o);
				failures++;
				return;
			end
			v = pending_verdicts.pop_front();
			if (m !== v.matched) begin
				$error("matched: expected %0d, actual %0d", v.matched, m);
				failures++;
			end
			if (o !== v.overflow) begin
				$error("overflow: expected %0d, actual %0d", v.overflow, o);
				failures++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic operation;
	logic [7:0] char_value;
	logic out_valid;
	logic out_stall;
	logic matched;
	logic overflow;
	logic cfg_valid;
	logic cfg_ready;
	logic case_mode;

	match_tracker tracker = new();
	bit tx_idle_on;
	bit rx_idle_on;
	int items_sent;
	int pairs_sent;

	localparam int ITEM_GOAL = 1850;
	localparam int PHASES = 6;

	glob_wildcard_matcher DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.char_value(char_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.matched(matched),
		.overflow(overflow),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.case_mode(case_mode)
	);

	always #5 clk = ~clk;

	initial begin : watchdog
		#20_000_000;
		$display("FAIL glob_wildcard_matcher");
		$finish;
	end

	initial begin : receiver
		int stall_left;
		stall_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0)
				stall_left--;
			else if (rx_idle_on && $urandom_range(0, 7) == 0)
				stall_left = $urandom_range(1, 14);
			out_stall = (stall_left > 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_verdict(matched, overflow);
	end

	task automatic send_byte(input logic op, input logic [7:0] ch);
		int gap;
		if (tx_idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		operation = op;
		char_value = ch;
		do @(posedge clk); while (in_stall);
		tracker.take_byte(op, ch);
		if (!(op == gwm_pkg::OP_PATTERN && ch == 8'h00))
			items_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (tracker.pending_verdicts.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_case_mode(input logic v);
		cfg_valid = 1'b1;
		case_mode = v;
		do @(posedge clk); while (!cfg_ready);
		tracker.fold_case = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_text(input logic op, input string txt);
		for (int i = 0; i < txt.len(); i++)
			send_byte(op, txt[i]);
	endtask

	function automatic logic [7:0] rand_char();
		case ($urandom_range(0, 9))
			0: return 8'($urandom_range(1, 255));
			1: return $urandom_range(0, 1) ? gwm_pkg::CH_STAR : gwm_pkg::CH_QUES;
			2, 3: return 8'("A" + $urandom_range(0, 2));
			default: return 8'("a" + $urandom_range(0, 2));
		endcase
	endfunction

	function automatic byte_q_t pattern_from(byte_q_t sq);
		byte_q_t pq;
		int k;
		logic [7:0] c;
		k = 0;
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(0, 10)) pq.push_back(rand_char());
			return pq;
		end
		while (k < sq.size()) begin
			case ($urandom_range(0, 11))
				0: begin
					pq.push_back(gwm_pkg::CH_QUES);
					k++;
				end
				1: begin
					pq.push_back(gwm_pkg::CH_STAR);
					k += $urandom_range(0, 3);
				end
				2: begin
					pq.push_back(rand_char());
					k++;
				end
				3: begin
					c = sq[k];
					if ((c | 8'h20) >= "a" && (c | 8'h20) <= "z")
						c = c ^ 8'h20;
					pq.push_back(c);
					k++;
				end
				4: k++;
				5: pq.push_back(gwm_pkg::CH_STAR);
				default: begin
					pq.push_back(sq[k]);
					k++;
				end
			endcase
		end
		case ($urandom_range(0, 7))
			0: pq.push_back(gwm_pkg::CH_STAR);
			1: pq.push_back(rand_char());
			default: ;
		endcase
		while (pq.size() > gwm_pkg::MAX_PATTERN_DEF)
			void'(pq.pop_back());
		return pq;
	endfunction

	task automatic send_pair(input byte_q_t pq, input byte_q_t sq);
		int i;
		int j;
		bit mix;
		bit end_mark;
		i = 0;
		j = 0;
		mix = ($urandom_range(0, 3) == 0);
		end_mark = ($urandom_range(0, 1) == 1);
		while (i < pq.size() || j < sq.size()) begin
			if (i < pq.size() && (j >= sq.size() || !mix || $urandom_range(0, 1))) begin
				if ($urandom_range(0, 19) == 0)
					send_byte(gwm_pkg::OP_PATTERN, 8'h00);
				send_byte(gwm_pkg::OP_PATTERN, pq[i]);
				i++;
				if (i == pq.size() && end_mark)
					send_byte(gwm_pkg::OP_PATTERN, 8'h00);
			end else begin
				send_byte(gwm_pkg::OP_SUBJECT, sq[j]);
				j++;
			end
		end
		send_byte(gwm_pkg::OP_SUBJECT, 8'h00);
		pairs_sent++;
	endtask

	task automatic send_long_pair(input int plen, input int slen);
		byte_q_t pq;
		byte_q_t sq;
		repeat (slen) sq.push_back($urandom_range(0, 1) ? "a" : "b");
		repeat (plen) begin
			case ($urandom_range(0, 3))
				0: pq.push_back(gwm_pkg::CH_STAR);
				1: pq.push_back(gwm_pkg::CH_QUES);
				2: pq.push_back("a");
				default: pq.push_back("b");
			endcase
		end
		send_pair(pq, sq);
	endtask

	task automatic send_random_pair();
		byte_q_t sq;
		int r;
		if ($urandom_range(0, 11) == 0)
			drain();
		r = $urandom_range(0, 99);
		if (r < 2)
			send_long_pair($urandom_range(65, 68), $urandom_range(0, 8));
		else if (r < 3)
			send_long_pair($urandom_range(1, 64), $urandom_range(100, 256));
		else if (r < 4)
			send_long_pair($urandom_range(0, 6), $urandom_range(257, 259));
		else begin
			repeat ($urandom_range(0, 14)) sq.push_back(rand_char());
			send_pair(pattern_from(sq), sq);
		end
	endtask

	initial begin : stimulus
		logic mode_plan[PHASES];
		mode_plan = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = gwm_pkg::OP_PATTERN;
		char_value = 8'h00;
		cfg_valid = 1'b0;
		case_mode = 1'b1;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		items_sent = 0;
		pairs_sent = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_byte(gwm_pkg::OP_SUBJECT, 8'h00);
		send_byte(gwm_pkg::OP_PATTERN, 8'h00);
		send_text(gwm_pkg::OP_SUBJECT, "a");
		send_byte(gwm_pkg::OP_SUBJECT, 8'h00);
		send_byte(gwm_pkg::OP_PATTERN, gwm_pkg::CH_STAR);
		send_byte(gwm_pkg::OP_SUBJECT, 8'h00);
		send_text(gwm_pkg::OP_PATTERN, "A");
		send_text(gwm_pkg::OP_SUBJECT, "a");
		send_text(gwm_pkg::OP_PATTERN, "?");
		send_text(gwm_pkg::OP_SUBJECT, "X");
		send_text(gwm_pkg::OP_PATTERN, "c*");
		send_text(gwm_pkg::OP_SUBJECT, "C");
		send_byte(gwm_pkg::OP_SUBJECT, 8'h00);
		send_byte(gwm_pkg::OP_PATTERN, 8'hFF);
		send_byte(gwm_pkg::OP_PATTERN, 8'h80);
		send_byte(gwm_pkg::OP_SUBJECT, 8'hFF);
		send_byte(gwm_pkg::OP_SUBJECT, 8'h01);
		send_byte(gwm_pkg::OP_SUBJECT, 8'h00);
		send_text(gwm_pkg::OP_PATTERN, "*?");
		send_byte(gwm_pkg::OP_SUBJECT, 8'h00);

		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			write_case_mode(mode_plan[phase]);
			tx_idle_on = (phase == 0 || phase == 1 || phase == 4);
			rx_idle_on = (phase == 0 || phase == 2 || phase == 4);
			if (phase == 0) begin
				send_long_pair(gwm_pkg::MAX_PATTERN_DEF + 1, 3);
				send_long_pair(2, gwm_pkg::MAX_SUBJECT_DEF + 1);
				send_long_pair(gwm_pkg::MAX_PATTERN_DEF, gwm_pkg::MAX_SUBJECT_DEF);
			end
			while (items_sent < ITEM_GOAL * (phase + 1) / PHASES)
				send_random_pair();
		end

		drain();
		$display("Sent %0d bytes in %0d string pairs: %0d matched, %0d mismatched, %0d overflowed.",
			items_sent, pairs_sent, tracker.n_hit, tracker.n_miss, tracker.n_overflow);
		$display("Both case modes, interleaved loads, full stores and stalls on both sides ran.");
		if (tracker.failures == 0)
			$display("PASS glob_wildcard_matcher");
		else
			$display("FAIL glob_wildcard_matcher");
		$finish;
	end

endmodule
